[rtl/bhpq_pkg.sv]
// Shared types and constants for the binary heap priority queue.
// Used by bhpq_mem, bhpq_sift and binary_heap_priority_queue; no dependencies.
package bhpq_pkg;

	localparam int DEPTH = 64;
	localparam int KEY_W = 32;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic {
		CMD_PUSH = 1'b0,
		CMD_POP  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		cmd_t                    cmd;
		logic signed [KEY_W-1:0] key_in;
	} in_item_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] top_key;
		logic                    is_empty;
		logic [CNT_W-1:0]        entry_count;
		status_t                 status;
	} out_item_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		logic [KEY_W-1:0] wdata;
		logic [IDX_W-1:0] raddr_a;
		logic [IDX_W-1:0] raddr_b;
	} mem_req_t;

endpackage

[rtl/bhpq_mem.sv]
// Heap key store: one write port, two read ports with registered data.
// Depends on bhpq_pkg for the request struct and sizes.
module bhpq_mem import bhpq_pkg::*; (
	input  logic             clk,
	input  mem_req_t         req,
	output logic [KEY_W-1:0] rd_a,
	output logic [KEY_W-1:0] rd_b
);

	logic [KEY_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rd_a <= mem[req.raddr_a];
		rd_b <= mem[req.raddr_b];
	end

endmodule

[rtl/bhpq_sift.sv]
// Heap sequencer: push with sift-up, pop with sift-down, over bhpq_mem.
// Depends on bhpq_pkg for item, result and memory request types.
module bhpq_sift import bhpq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             min_first,
	input  logic             start,
	input  in_item_t         item,
	output logic             idle,
	output mem_req_t         mem_req,
	input  logic [KEY_W-1:0] rd_a,
	input  logic [KEY_W-1:0] rd_b,
	output logic             done,
	output out_item_t        result
);

	localparam int WIDE_W = IDX_W + 2;

	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_UP      = 7'b0000010,
		S_UP_CMP  = 7'b0000100,
		S_DN_LAST = 7'b0001000,
		S_DN      = 7'b0010000,
		S_DN_CMP  = 7'b0100000,
		S_FIN     = 7'b1000000
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] now_q;
	logic [KEY_W-1:0] cur_q;
	logic [KEY_W-1:0] root_q;
	status_t          status_q;

	// true when key a is strictly ahead of key b in serving order
	function automatic logic better(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b,
		input logic mf);
		logic lt;
		logic gt;
		lt = $signed(a) < $signed(b);
		gt = $signed(a) > $signed(b);
		return mf ? lt : gt;
	endfunction

	logic [IDX_W-1:0]  parent;
	logic [WIDE_W-1:0] left_w;
	logic [WIDE_W-1:0] right_w;
	logic [WIDE_W-1:0] cnt_w;
	logic              left_ok;
	logic              right_ok;
	logic              up_stop;
	logic              l_better;
	logic              r_better;
	logic [KEY_W-1:0]  best_l;
	logic [KEY_W-1:0]  best;
	logic              moving;

	assign parent   = IDX_W'((now_q - 1'b1) >> 1);
	assign left_w   = {1'b0, now_q, 1'b1};
	assign right_w  = left_w + 1'b1;
	assign cnt_w    = {{(WIDE_W - CNT_W){1'b0}}, cnt_q};
	assign left_ok  = left_w < cnt_w;
	assign right_ok = right_w < cnt_w;
	assign up_stop  = better(rd_a, cur_q, min_first);
	assign l_better = better(rd_a, cur_q, min_first);
	assign best_l   = l_better ? rd_a : cur_q;
	assign r_better = right_ok && better(rd_b, best_l, min_first);
	assign best     = r_better ? rd_b : best_l;
	assign moving   = l_better || r_better;

	always_comb begin
		mem_req = '0;
		unique case (state_q)
			S_IDLE: begin
				// fetch the last entry for a pop
				mem_req.raddr_a = IDX_W'(cnt_q - 1'b1);
			end
			S_UP: begin
				if (now_q == '0) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = now_q;
					mem_req.wdata = cur_q;
				end else begin
					mem_req.raddr_a = parent;
				end
			end
			S_UP_CMP: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = now_q;
				mem_req.wdata = up_stop ? cur_q : rd_a;
			end
			S_DN: begin
				if (left_ok) begin
					mem_req.raddr_a = left_w[IDX_W-1:0];
					mem_req.raddr_b = right_w[IDX_W-1:0];
				end else begin
					mem_req.we    = 1'b1;
					mem_req.waddr = now_q;
					mem_req.wdata = cur_q;
				end
			end
			S_DN_CMP: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = now_q;
				mem_req.wdata = moving ? best : cur_q;
			end
			S_DN_LAST, S_FIN: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			now_q    <= '0;
			cur_q    <= '0;
			status_q <= ST_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						status_q <= ST_OK;
						if (item.cmd == CMD_PUSH) begin
							if (cnt_q == CNT_W'(DEPTH)) begin
								status_q <= ST_FULL;
								state_q  <= S_FIN;
							end else begin
								now_q   <= IDX_W'(cnt_q);
								cur_q   <= item.key_in;
								cnt_q   <= cnt_q + 1'b1;
								state_q <= S_UP;
							end
						end else begin
							if (cnt_q == '0) begin
								status_q <= ST_EMPTY;
								state_q  <= S_FIN;
							end else begin
								cnt_q   <= cnt_q - 1'b1;
								state_q <= S_DN_LAST;
							end
						end
					end
				end
				S_UP: begin
					state_q <= (now_q == '0) ? S_FIN : S_UP_CMP;
				end
				S_UP_CMP: begin
					if (up_stop) begin
						state_q <= S_FIN;
					end else begin
						now_q   <= parent;
						state_q <= S_UP;
					end
				end
				S_DN_LAST: begin
					cur_q   <= rd_a;
					now_q   <= '0;
					state_q <= (cnt_q == '0) ? S_FIN : S_DN;
				end
				S_DN: begin
					state_q <= left_ok ? S_DN_CMP : S_FIN;
				end
				S_DN_CMP: begin
					if (moving) begin
						now_q   <= r_better ? right_w[IDX_W-1:0] : left_w[IDX_W-1:0];
						state_q <= S_DN;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// mirror of entry 0 so the top key needs no extra read
	always_ff @(posedge clk) begin
		if (mem_req.we && mem_req.waddr == '0) begin
			root_q <= mem_req.wdata;
		end
	end

	assign idle = state_q == S_IDLE;
	assign done = state_q == S_FIN;

	always_comb begin
		result.top_key     = (cnt_q != '0) ? root_q : '0;
		result.is_empty    = cnt_q == '0;
		result.entry_count = cnt_q;
		result.status      = status_q;
	end

endmodule

[rtl/binary_heap_priority_queue.sv]
// Top level of the binary heap priority queue: config register, result register.
// Depends on bhpq_pkg, bhpq_mem and bhpq_sift.
//
// Priority queue of signed keys held as a binary heap in a two-read, one-write
// memory with registered read data. Each input item is a push (cmd 0) or a
// pop (cmd 1); each returns one result item with the key now at the top (zero
// when empty), the empty flag, the entry count and a status (ok, pop on empty
// ignored, push on full dropped; a flagged item leaves the store untouched).
// One item is in work at a time. A push climbs from the next free slot until
// its key reaches the root or stops below a parent; a pop moves the last entry
// to the root and sinks it until it stops above its children or reaches a
// leaf, unless it empties the heap. Each heap level takes a memory read and
// then a compare-and-write; a flagged item goes straight to its result.
// Every result passes through the result register. The next item is taken
// while the previous result is being handed over. min_first (reset 1) picks
// smallest-first order; write it only while idle. Changing it with entries
// held does not reorder them.
module binary_heap_priority_queue import bhpq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_data,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);

	logic             min_first_q;
	logic             sift_idle;
	logic             sift_done;
	logic             start;
	mem_req_t         mem_req;
	logic [KEY_W-1:0] rd_a;
	logic [KEY_W-1:0] rd_b;
	out_item_t        result;
	logic             out_valid_q;
	out_item_t        out_item_q;

	// order select register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_first_q <= 1'b1;
		end else if (cfg_we) begin
			min_first_q <= cfg_data;
		end
	end

	// take an item when the sequencer is idle and the result slot is free or
	// emptying this cycle
	assign in_stall = !(sift_idle && (!out_valid_q || !out_stall));
	assign start    = in_valid && !in_stall;

	bhpq_mem u_mem (
		.clk  (clk),
		.req  (mem_req),
		.rd_a (rd_a),
		.rd_b (rd_b)
	);

	bhpq_sift u_sift (
		.clk       (clk),
		.arst_n    (arst_n),
		.min_first (min_first_q),
		.start     (start),
		.item      (in_item),
		.idle      (sift_idle),
		.mem_req   (mem_req),
		.rd_a      (rd_a),
		.rd_b      (rd_b),
		.done      (sift_done),
		.result    (result)
	);

	// result register: load on completion, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (sift_done) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sift_done) begin
			out_item_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

[bench/tb.sv]
// Self-checking bench for binary_heap_priority_queue: a directed table, then random phases.
// Depends on bhpq_pkg for the item types, the codes and the heap depth.
`timescale 1ns / 1ps

module tb;
	import bhpq_pkg::*;

	localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fffffff;
	localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh80000000;
	localparam out_item_t NO_WANT = '0;
	// Longest quiet stretch that a correct run can show: the long receiver
	// hold-off below plus random stall streaks, taken many times over.
	localparam int QUIET_LIMIT = 5000;
	// A push climbs at most six levels, then passes through the result register.
	localparam int DRAIN_CYCLES = 20;
	localparam int HOLD_OFF_CYCLES = 200;
	localparam int HOLD_OFF_AT = 40;

	// One row of the directed table: either a register write or an item.
	// Where typed is set, want is the result read straight off the behavior.
	typedef struct {
		bit                      cfg;
		bit                      cfg_val;
		cmd_t                    cmd;
		logic signed [KEY_W-1:0] key;
		bit                      typed;
		out_item_t               want;
	} dir_row_t;

	localparam int N_ROWS = 22;

	dir_row_t dir_table [N_ROWS] = '{
		'{1'b1, 1'b1, CMD_PUSH, 32'sd0, 1'b0, NO_WANT},
		// pop on an empty heap right after reset
		'{1'b0, 1'b0, CMD_POP, KEY_MAX, 1'b1, '{32'sd0, 1'b1, 7'd0, ST_EMPTY}},
		'{1'b0, 1'b0, CMD_PUSH, KEY_MAX, 1'b1, '{KEY_MAX, 1'b0, 7'd1, ST_OK}},
		'{1'b0, 1'b0, CMD_PUSH, KEY_MIN, 1'b1, '{KEY_MIN, 1'b0, 7'd2, ST_OK}},
		'{1'b0, 1'b0, CMD_PUSH, 32'sd0, 1'b0, NO_WANT},
		'{1'b0, 1'b0, CMD_PUSH, -32'sd1, 1'b0, NO_WANT},
		// equal keys: the same key is pushed twice
		'{1'b0, 1'b0, CMD_PUSH, 32'sd5, 1'b0, NO_WANT},
		'{1'b0, 1'b0, CMD_PUSH, 32'sd5, 1'b0, NO_WANT},
		'{1'b0, 1'b0, CMD_POP, 32'sd0, 1'b0, NO_WANT},
		'{1'b0, 1'b0, CMD_POP, -32'sd1, 1'b0, NO_WANT},
		'{1'b0, 1'b0, CMD_POP, KEY_MIN, 1'b0, NO_WANT},
		// flip the order with three entries still held; nothing is reordered
		'{1'b1, 1'b0, CMD_PUSH, 32'sd0, 1'b0, NO_WANT},
		'{1'b0, 1'b0, CMD_PUSH, 32'sd1, 1'b0, NO_WANT},
		'{1'b0, 1'b0, CMD_PUSH, 32'sh55555555, 1'b0, NO_WANT},
		'{1'b0, 1'b0, CMD_PUSH, 32'shaaaaaaaa, 1'b0, NO_WANT},
		'{1'b0, 1'b0, CMD_POP, 32'sd0, 1'b0, NO_WANT},
		'{1'b0, 1'b0, CMD_POP, 32'sd0, 1'b0, NO_WANT},
		'{1'b0, 1'b0, CMD_POP, 32'sd0, 1'b0, NO_WANT},
		'{1'b0, 1'b0, CMD_POP, 32'sd0, 1'b0, NO_WANT},
		'{1'b0, 1'b0, CMD_POP, 32'sd0, 1'b0, NO_WANT},
		'{1'b0, 1'b0, CMD_POP, 32'sd0, 1'b0, NO_WANT},
		// drained again: one more pop is ignored
		'{1'b0, 1'b0, CMD_POP, KEY_MIN, 1'b1, '{32'sd0, 1'b1, 7'd0, ST_EMPTY}}
	};

	logic      clk;
	logic      arst_n;
	logic      cfg_we;
	logic      cfg_data;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_item;

	// Heap shadow: entries, fill level and serving order.
	logic signed [KEY_W-1:0] heap_q [DEPTH];
	int unsigned             held;
	bit                      order_min;

	out_item_t pending_results [$];
	int        send_idle;
	int        recv_idle;
	int        items_sent;
	int        results_seen;
	int        fails;

	binary_heap_priority_queue u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// True when key a is served strictly before key b under the current order.
	function automatic bit ahead(logic signed [KEY_W-1:0] a, logic signed [KEY_W-1:0] b);
		return order_min ? (a < b) : (a > b);
	endfunction

	function automatic void swap_slots(int unsigned a, int unsigned b);
		logic signed [KEY_W-1:0] tmp;
		tmp = heap_q[a];
		heap_q[a] = heap_q[b];
		heap_q[b] = tmp;
	endfunction

	// Apply one item to the shadow heap and return the result it must cause.
	function automatic out_item_t heap_apply(in_item_t it);
		out_item_t   res;
		int unsigned pos;
		int unsigned up;
		int unsigned lt;
		int unsigned rt;
		int unsigned nxt;
		bit          done;
		res = '0;
		res.status = ST_OK;
		done = 1'b0;
		if (it.cmd == CMD_PUSH) begin
			if (held >= DEPTH) begin
				res.status = ST_FULL;
			end else begin
				// append, then climb while the parent is not strictly ahead
				pos = held;
				heap_q[pos] = it.key_in;
				held++;
				while (pos > 0 && !done) begin
					up = (pos - 1) / 2;
					if (ahead(heap_q[up], heap_q[pos])) begin
						done = 1'b1;
					end else begin
						swap_slots(pos, up);
						pos = up;
					end
				end
			end
		end else if (held == 0) begin
			res.status = ST_EMPTY;
		end else begin
			// move the last entry to the root and sink it; the left child wins ties
			held--;
			heap_q[0] = heap_q[held];
			pos = 0;
			while (!done) begin
				lt = 2 * pos + 1;
				rt = lt + 1;
				nxt = pos;
				if (lt >= held) begin
					done = 1'b1;
				end else begin
					if (ahead(heap_q[lt], heap_q[nxt]))
						nxt = lt;
					if (rt < held && ahead(heap_q[rt], heap_q[nxt]))
						nxt = rt;
					if (nxt == pos) begin
						done = 1'b1;
					end else begin
						swap_slots(pos, nxt);
						pos = nxt;
					end
				end
			end
		end
		res.top_key = (held != 0) ? heap_q[0] : '0;
		res.is_empty = (held == 0);
		res.entry_count = CNT_W'(held);
		return res;
	endfunction

	// Offer one item, hold it until taken, then queue the result it must cause.
	task automatic drive_item(in_item_t it, bit typed, out_item_t want);
		out_item_t predicted;
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predicted = heap_apply(it);
		pending_results = {pending_results, (typed ? want : predicted)};
		items_sent++;
	endtask

	// Write the order bit once the block is idle: nothing in flight, nothing owed.
	task automatic write_order(bit val);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		order_min = val;
	endtask

	// Keys: full range, a narrow band that yields duplicates, and the extremes.
	function automatic logic signed [KEY_W-1:0] pick_key();
		case ($urandom_range(3))
			0: return $urandom_range(15) - 8;
			1: begin
				case ($urandom_range(3))
					0: return KEY_MAX;
					1: return KEY_MIN;
					2: return '0;
					default: return -1;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	function automatic in_item_t make_item(cmd_t c);
		in_item_t it;
		it.cmd = c;
		it.key_in = pick_key();
		return it;
	endfunction

	// Random traffic: fill bursts up to and past full, drains down to and past
	// empty, and mixed runs in between.
	task automatic run_phase(int n_items);
		int target;
		int len;
		target = items_sent + n_items;
		while (items_sent < target) begin
			case ($urandom_range(9))
				0, 1, 2: begin
					while (held < DEPTH)
						drive_item(make_item(CMD_PUSH), 1'b0, NO_WANT);
					repeat ($urandom_range(3, 1))
						drive_item(make_item(CMD_PUSH), 1'b0, NO_WANT);
				end
				3, 4: begin
					while (held > 0)
						drive_item(make_item(CMD_POP), 1'b0, NO_WANT);
					repeat ($urandom_range(2, 1))
						drive_item(make_item(CMD_POP), 1'b0, NO_WANT);
				end
				default: begin
					len = $urandom_range(30, 10);
					repeat (len)
						drive_item(make_item(($urandom_range(99) < 60) ? CMD_PUSH : CMD_POP),
							1'b0, NO_WANT);
				end
			endcase
		end
	endtask

	// Compare one taken result with the oldest one owed.
	task automatic check_result(out_item_t got);
		out_item_t want;
		if (pending_results.size() == 0) begin
			$error("result with no item pending: top_key %0d count %0d",
				got.top_key, got.entry_count);
			fails++;
		end else begin
			want = pending_results.pop_front();
			if (got.top_key !== want.top_key) begin
				$error("top_key: expected %0d, got %0d", want.top_key, got.top_key);
				fails++;
			end
			if (got.is_empty !== want.is_empty) begin
				$error("is_empty: expected %0b, got %0b", want.is_empty, got.is_empty);
				fails++;
			end
			if (got.entry_count !== want.entry_count) begin
				$error("entry_count: expected %0d, got %0d", want.entry_count,
					got.entry_count);
				fails++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				fails++;
			end
		end
		results_seen++;
	endtask

	// Receiver: take results, stall at random, and once hold off for a long
	// stretch so that the block fills up and stalls its input.
	initial begin
		int  hold_left;
		bit  held_off;
		hold_left = 0;
		held_off = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall)
				check_result(out_item);
			if (!held_off && results_seen == HOLD_OFF_AT) begin
				held_off = 1'b1;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle);
			end
		end
	end

	// Watchdog: end the run when nothing moves on either side for too long.
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		in_item_t it;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		send_idle = 27;
		recv_idle = 77;
		items_sent = 0;
		results_seen = 0;
		fails = 0;
		held = 0;
		order_min = 1'b1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table.
		for (int r = 0; r < N_ROWS; r++) begin
			if (dir_table[r].cfg) begin
				write_order(dir_table[r].cfg_val);
			end else begin
				it.cmd = dir_table[r].cmd;
				it.key_in = dir_table[r].key;
				drive_item(it, dir_table[r].typed, dir_table[r].want);
			end
		end

		// Sender eager, receiver mostly stalled; the long hold-off falls here.
		write_order(1'b1);
		run_phase(250);

		// Sender mostly idle, receiver eager.
		write_order(1'b0);
		send_idle = 77;
		recv_idle = 27;
		run_phase(250);

		// Back to back on both sides.
		write_order(1'b1);
		send_idle = 0;
		recv_idle = 0;
		run_phase(250);

		// Drain: wait for every owed result, then let the block settle.
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
